### sv/band_threshold_row_level_finder_macros.svh
// Assertion macros for the band threshold row level finder.
// Used by the top level only; no other dependencies.
`ifndef BAND_THRESHOLD_ROW_LEVEL_FINDER_MACROS_SVH
`define BAND_THRESHOLD_ROW_LEVEL_FINDER_MACROS_SVH

// same-cycle implication
`define BTRL_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("btrl assertion failed");

// next-cycle implication
`define BTRL_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("btrl assertion failed");

`endif

### sv/btrl_pkg.sv
// Shared constants and types for the band threshold row level finder.
// No dependencies; imported by the front end, back end and top level of the block.
package btrl_pkg;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int TOTAL_W    = 21;
  localparam int ROWCNT_W   = 11;
  localparam int LEVEL_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [ROWCNT_W-1:0] ROW_SAT   = '1;
  localparam logic [TOTAL_W-1:0]  FRAME_SAT = '1;
  localparam logic [LEVEL_W-1:0]  FULL_Q8   = 15'd25600;

  localparam logic [PIX_W-1:0]   BAND_LOW_RST   = 8'd80;
  localparam logic [PIX_W-1:0]   BAND_HIGH_RST  = 8'd140;
  localparam logic [TOTAL_W-1:0] MIN_TOTAL_RST  = 21'd50;
  localparam logic [SIZE_W-1:0]  WIDTH_RST      = 11'd160;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST     = 11'd240;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;

  typedef enum logic [1:0] {
    OUTC_ROW     = 2'd0,
    OUTC_DRY     = 2'd1,
    OUTC_DENSITY = 2'd2
  } btrl_outcome_t;

  typedef struct packed {
    logic [PIX_W-1:0]   band_low;
    logic [PIX_W-1:0]   band_high;
    logic [TOTAL_W-1:0] min_total;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
  } btrl_cfg_t;

endpackage

### sv/btrl_queue.sv
// Short first-in first-out queue of frame jobs between front and back.
// Generic data width; uses no package items.
module btrl_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     fill;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (fill != NW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entry[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/btrl_front.sv
// Front end: takes pixels, classifies them against the band, keeps row and
// frame counts and the best row, and pushes one job per frame. Uses btrl_pkg.
module btrl_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  btrl_pkg::btrl_cfg_t                  cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [btrl_pkg::PIX_W-1:0]           gray_pixel,
  output logic                                 job_valid,
  input  logic                                 job_ready,
  output btrl_pkg::btrl_outcome_t              job_outcome,
  output logic [btrl_pkg::TOTAL_W-1:0]         job_num,
  output logic [$clog2(MAX_WIDTH+1)-1:0]       job_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]      job_h,
  output logic [btrl_pkg::TOTAL_W-1:0]         job_total
);

  import btrl_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EWW = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int EHW = (HW > SIZE_W) ? HW : SIZE_W;
  localparam int QW  = (WW > ROWCNT_W) ? WW : ROWCNT_W;

  logic [CW-1:0]       column_pos;
  logic [RW-1:0]       row_pos;
  logic [ROWCNT_W-1:0] row_water;
  logic [ROWCNT_W-1:0] best_row_water;
  logic [RW-1:0]       best_row_index;
  logic                row_found;
  logic [TOTAL_W-1:0]  frame_water;

  logic [EWW-1:0]      width_ext;
  logic [EHW-1:0]      height_ext;
  logic [WW-1:0]       w;
  logic [HW-1:0]       h;
  logic [WW-1:0]       col_inc;
  logic [HW-1:0]       row_inc;
  logic                row_end;
  logic                frame_end;
  logic                accept;
  logic                is_water;
  logic [ROWCNT_W-1:0] row_water_next;
  logic [TOTAL_W-1:0]  frame_water_next;
  logic                take_row;
  logic [RW-1:0]       best_index_next;
  logic                found_next;
  logic                index_ok;

  assign width_ext  = EWW'(cfg.width);
  assign height_ext = EHW'(cfg.height);
  assign w = (cfg.width == '0) ? WW'(1) :
             (width_ext > EWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
  assign h = (cfg.height == '0) ? HW'(1) :
             (height_ext > EHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);

  assign col_inc   = WW'(column_pos) + WW'(1);
  assign row_inc   = HW'(row_pos) + HW'(1);
  assign row_end   = (col_inc >= w);
  assign frame_end = row_end && (row_inc >= h);

  // stall only when a frame would close into a full queue
  assign in_ready  = !(frame_end && !job_ready);
  assign accept    = in_valid && in_ready;

  assign is_water = (gray_pixel >= cfg.band_low) && (gray_pixel <= cfg.band_high);
  assign row_water_next = (is_water && row_water != ROW_SAT) ?
                          row_water + 1'b1 : row_water;
  assign frame_water_next = (is_water && frame_water != FRAME_SAT) ?
                            frame_water + 1'b1 : frame_water;

  assign take_row = (row_water_next > best_row_water) &&
                    (QW'(row_water_next) > QW'(w >> 2));
  assign best_index_next = take_row ? row_pos : best_row_index;
  assign found_next      = row_found || take_row;
  assign index_ok        = (HW'(best_index_next) < h);

  assign job_valid = accept && frame_end;
  assign job_total = frame_water_next;
  assign job_w     = w;
  assign job_h     = h;

  always_comb begin
    if (frame_water_next < cfg.min_total) begin
      job_outcome = OUTC_DRY;
      job_num     = '0;
    end else if (found_next) begin
      job_outcome = OUTC_ROW;
      job_num     = index_ok ? TOTAL_W'(h - HW'(best_index_next)) : '0;
    end else begin
      job_outcome = OUTC_DENSITY;
      job_num     = frame_water_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos     <= '0;
      row_pos        <= '0;
      row_water      <= '0;
      best_row_water <= '0;
      best_row_index <= '0;
      row_found      <= 1'b0;
      frame_water    <= '0;
    end else if (accept) begin
      if (!row_end) begin
        column_pos  <= CW'(col_inc);
        row_water   <= row_water_next;
        frame_water <= frame_water_next;
      end else if (!frame_end) begin
        column_pos  <= '0;
        row_water   <= '0;
        row_pos     <= RW'(row_inc);
        frame_water <= frame_water_next;
        if (take_row) begin
          best_row_water <= row_water_next;
          best_row_index <= row_pos;
          row_found      <= 1'b1;
        end
      end else begin
        column_pos     <= '0;
        row_pos        <= '0;
        row_water      <= '0;
        best_row_water <= '0;
        best_row_index <= '0;
        row_found      <= 1'b0;
        frame_water    <= '0;
      end
    end
  end

endmodule

### sv/btrl_back.sv
// Back end: turns a frame job into the level word with a multiply and a
// bit-serial restoring divider, and holds the result word. Uses btrl_pkg.
module btrl_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 job_valid,
  output logic                                 job_ready,
  input  btrl_pkg::btrl_outcome_t              job_outcome,
  input  logic [btrl_pkg::TOTAL_W-1:0]         job_num,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       job_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      job_h,
  input  logic [btrl_pkg::TOTAL_W-1:0]         job_total,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [btrl_pkg::LEVEL_W-1:0]         level_q8,
  output btrl_pkg::btrl_outcome_t              outcome,
  output logic [btrl_pkg::TOTAL_W-1:0]         water_total
);

  import btrl_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int DVW = WW + HW;
  localparam int DDW = TOTAL_W + LEVEL_W;
  localparam int KW  = $clog2(DDW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_HOLD
  } state_t;

  state_t             state;
  logic [TOTAL_W-1:0] num;
  logic [WW-1:0]      w_job;
  logic [HW-1:0]      h_job;
  logic [DDW-1:0]     quot;
  logic [DVW-1:0]     divisor;
  logic [DVW-1:0]     rem;
  logic [KW-1:0]      step;

  logic [DVW:0]       trial;
  logic               fits;
  logic [DVW-1:0]     rem_next;

  assign job_ready = (state == ST_IDLE);

  assign trial    = {rem, quot[DDW-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign rem_next = fits ? DVW'(trial - {1'b0, divisor}) : DVW'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            num         <= job_num;
            w_job       <= job_w;
            h_job       <= job_h;
            outcome     <= job_outcome;
            water_total <= job_total;
            state       <= ST_MUL;
          end
        end
        ST_MUL: begin
          quot    <= DDW'(num) * DDW'(FULL_Q8);
          divisor <= (outcome == OUTC_ROW) ? DVW'(h_job) : DVW'(w_job) * DVW'(h_job);
          rem     <= '0;
          step    <= KW'(DDW - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= rem_next;
          quot <= {quot[DDW-2:0], fits};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          level_q8  <= (quot > DDW'(FULL_Q8)) ? FULL_Q8 : LEVEL_W'(quot);
          out_valid <= 1'b1;
          state     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/band_threshold_row_level_finder.sv
// Top level of the band threshold row level finder: configuration registers,
// front end, job queue and back end. Uses btrl_pkg and the macros header.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------
//   in      | in        | in_valid / in_ready   | gray_pixel
//   out     | out       | out_valid / out_ready | level_q8, outcome, water_total
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel a cycle is taken by the front end; each frame closes into a
// two-entry job queue. For each frame the back end runs a multiply state,
// bit-serial divider steps over all quotient bits and a saturate state; short
// frames fill the queue and the input then stalls on the last pixel of a frame.
// Synchronous reset clears counters, queue and result valid; registers take
// their defaults. Configuration is always ready and takes effect at once.
module band_threshold_row_level_finder #(
  parameter int MAX_WIDTH  = btrl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = btrl_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [btrl_pkg::PIX_W-1:0]        gray_pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [btrl_pkg::LEVEL_W-1:0]      level_q8,
  output logic [1:0]                        outcome,
  output logic [btrl_pkg::TOTAL_W-1:0]      water_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [btrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btrl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import btrl_pkg::*;

  `include "band_threshold_row_level_finder_macros.svh"

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int JOB_W = 2 + TOTAL_W + WW + HW + TOTAL_W;

  btrl_cfg_t          cfg;
  logic               job_valid;
  logic               q_push_ready;
  btrl_outcome_t      job_outcome;
  logic [TOTAL_W-1:0] job_num;
  logic [WW-1:0]      job_w;
  logic [HW-1:0]      job_h;
  logic [TOTAL_W-1:0] job_total;
  logic [JOB_W-1:0]   push_data;
  logic [JOB_W-1:0]   pop_data;
  logic               q_pop_valid;
  logic               q_pop_ready;
  btrl_outcome_t      back_outcome;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_low  <= BAND_LOW_RST;
      cfg.band_high <= BAND_HIGH_RST;
      cfg.min_total <= MIN_TOTAL_RST;
      cfg.width     <= WIDTH_RST;
      cfg.height    <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BAND_LOW:  cfg.band_low  <= cfg_data[PIX_W-1:0];
        CFG_BAND_HIGH: cfg.band_high <= cfg_data[PIX_W-1:0];
        CFG_MIN_TOTAL: cfg.min_total <= cfg_data[TOTAL_W-1:0];
        CFG_WIDTH:     cfg.width     <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:    cfg.height    <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  btrl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .gray_pixel  (gray_pixel),
    .job_valid   (job_valid),
    .job_ready   (q_push_ready),
    .job_outcome (job_outcome),
    .job_num     (job_num),
    .job_w       (job_w),
    .job_h       (job_h),
    .job_total   (job_total)
  );

  assign push_data = {job_outcome, job_num, job_w, job_h, job_total};

  btrl_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (q_push_ready),
    .push_data  (push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (pop_data)
  );

  btrl_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_pop_valid),
    .job_ready   (q_pop_ready),
    .job_outcome (btrl_outcome_t'(pop_data[JOB_W-1 -: 2])),
    .job_num     (pop_data[JOB_W-3 -: TOTAL_W]),
    .job_w       (pop_data[TOTAL_W+HW+WW-1 -: WW]),
    .job_h       (pop_data[TOTAL_W+HW-1 -: HW]),
    .job_total   (pop_data[TOTAL_W-1:0]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_q8    (level_q8),
    .outcome     (back_outcome),
    .water_total (water_total)
  );

  assign outcome = back_outcome;

  `BTRL_ASSERT_IMPLY(a_level_range, clk, rst, out_valid, level_q8 <= FULL_Q8)
  `BTRL_ASSERT_IMPLY(a_dry_zero, clk, rst, out_valid && outcome == OUTC_DRY, level_q8 == '0)
  `BTRL_ASSERT_IMPLY(a_stall_full, clk, rst, !in_ready, !q_push_ready)
  `BTRL_ASSERT_NEXT(a_pop_busy, clk, rst, q_pop_valid && q_pop_ready, !out_valid)

endmodule

### verif/btrl_level_check.sv
`timescale 1ns / 100ps
// Checker for the band threshold row level finder: watches the pixel, result
// and register channels, predicts each frame's level word and compares it.
// Depends on btrl_pkg only.
module btrl_level_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [btrl_pkg::PIX_W-1:0]      gray_pixel,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [btrl_pkg::LEVEL_W-1:0]    level_q8,
  input  logic [1:0]                      outcome,
  input  logic [btrl_pkg::TOTAL_W-1:0]    water_total,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [btrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btrl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              failures,
  output int                              pending
);

  import btrl_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    btrl_outcome_t      kind;
    logic [TOTAL_W-1:0] total;
  } level_word_t;

  btrl_cfg_t          regs;
  logic [9:0]         col_pos;
  logic [9:0]         row_pos;
  logic [9:0]         best_row;
  logic [ROWCNT_W-1:0] row_water;
  logic [ROWCNT_W-1:0] best_water;
  logic               row_seen;
  logic [TOTAL_W-1:0] frame_water;
  level_word_t        expected_levels[$];
  level_word_t        oldest;

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  task automatic clear_frame();
    col_pos     = '0;
    row_pos     = '0;
    row_water   = '0;
    best_water  = '0;
    best_row    = '0;
    row_seen    = 1'b0;
    frame_water = '0;
  endtask

  task automatic report_mismatch(string msg);
    failures++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic advance_frame(logic [PIX_W-1:0] pix);
    int unsigned       w;
    int unsigned       h;
    longint unsigned   lvl;
    level_word_t       word;
    w = eff_size(regs.width, DEF_MAX_WIDTH);
    h = eff_size(regs.height, DEF_MAX_HEIGHT);
    if (pix >= regs.band_low && pix <= regs.band_high) begin
      if (row_water != ROW_SAT) row_water++;
      if (frame_water != FRAME_SAT) frame_water++;
    end
    if (32'(col_pos) + 1 < w) begin
      col_pos++;
      return;
    end
    if (row_water > best_water && row_water > w / 4) begin
      best_water = row_water;
      best_row   = row_pos;
      row_seen   = 1'b1;
    end
    row_water = '0;
    col_pos   = '0;
    if (32'(row_pos) + 1 < h) begin
      row_pos++;
      return;
    end
    if (frame_water < regs.min_total) begin
      word.kind = OUTC_DRY;
      lvl = 0;
    end else if (row_seen) begin
      word.kind = OUTC_ROW;
      lvl = (best_row < h) ? 64'(h - best_row) * FULL_Q8 / h : 64'd0;
    end else begin
      word.kind = OUTC_DENSITY;
      lvl = 64'(frame_water) * FULL_Q8 / (64'(w) * h);
      if (lvl > FULL_Q8) lvl = FULL_Q8;
    end
    word.level = lvl[LEVEL_W-1:0];
    word.total = frame_water;
    expected_levels.push_back(word);
    clear_frame();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.band_low  = BAND_LOW_RST;
      regs.band_high = BAND_HIGH_RST;
      regs.min_total = MIN_TOTAL_RST;
      regs.width     = WIDTH_RST;
      regs.height    = HEIGHT_RST;
      clear_frame();
      expected_levels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          oldest = expected_levels.pop_front();
          if (level_q8 !== oldest.level)
            report_mismatch($sformatf("level_q8 %0d, expected %0d", level_q8, oldest.level));
          if (outcome !== oldest.kind)
            report_mismatch($sformatf("outcome %0d, expected %0d", outcome, oldest.kind));
          if (water_total !== oldest.total)
            report_mismatch($sformatf("water_total %0d, expected %0d",
                                      water_total, oldest.total));
        end
      end
      // a pixel taken at the same edge as a register write still sees the old value
      if (in_valid && in_ready) advance_frame(gray_pixel);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BAND_LOW:  regs.band_low  = cfg_data[PIX_W-1:0];
          CFG_BAND_HIGH: regs.band_high = cfg_data[PIX_W-1:0];
          CFG_MIN_TOTAL: regs.min_total = cfg_data[TOTAL_W-1:0];
          CFG_WIDTH:     regs.width     = cfg_data[SIZE_W-1:0];
          CFG_HEIGHT:    regs.height    = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_levels.size();
  end

endmodule

### verif/band_threshold_row_level_finder_test.sv
`timescale 1ns / 100ps
// Top of the band threshold row level finder testbench: clock, reset, pixel
// and register stimulus, result back-pressure and verdict.
// Depends on btrl_pkg, the block and btrl_level_check.
module band_threshold_row_level_finder_test;
  import btrl_pkg::*;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      gray_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LEVEL_W-1:0]    level_q8;
  logic [1:0]            outcome;
  logic [TOTAL_W-1:0]    water_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    failures;
  int                    pending;

  logic [PIX_W-1:0]  cur_low = BAND_LOW_RST;
  logic [PIX_W-1:0]  cur_high = BAND_HIGH_RST;
  int unsigned       cur_w = 32'(WIDTH_RST);
  int unsigned       cur_h = 32'(HEIGHT_RST);
  int                burst_left = 0;
  bit                steady = 1'b0;
  bit                calm = 1'b1;
  int                calm_span = 0;
  int                ready_hold = 0;
  int                random_sent = 0;
  int                phase_no = 0;

  band_threshold_row_level_finder dut (
    .clk, .rst, .in_valid, .in_ready, .gray_pixel,
    .out_valid, .out_ready, .level_q8, .outcome, .water_total,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  btrl_level_check level_check (
    .clk, .rst, .in_valid, .in_ready, .gray_pixel,
    .out_valid, .out_ready, .level_q8, .outcome, .water_total,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .failures, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("band_threshold_row_level_finder verification failed");
    $finish;
  end

  // result side: calm stretches and stretches of random stalls
  always @(negedge clk) begin
    if (calm_span == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      calm_span = $urandom_range(100, 400);
    end else begin
      calm_span--;
    end
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold == 0) begin
      out_ready <= ($urandom_range(0, 3) != 0);
      ready_hold = $urandom_range(0, 9);
    end else begin
      ready_hold--;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BAND_LOW:  cur_low  = data[PIX_W-1:0];
      CFG_BAND_HIGH: cur_high = data[PIX_W-1:0];
      CFG_WIDTH:     cur_w    = 32'(data[SIZE_W-1:0]);
      CFG_HEIGHT:    cur_h    = 32'(data[SIZE_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] p);
    @(negedge clk);
    in_valid   <= 1'b1;
    gray_pixel <= p;
    do @(posedge clk); while (!in_ready);
    if (!steady) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop valid, drain every pending word, then let the back end go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(cur_low, cur_high));
      4:          return cur_low;
      5:          return cur_high;
      6:          return 8'(cur_low - 1);
      7:          return 8'(cur_high + 1);
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic reshape_config();
    int unsigned lo;
    int unsigned hi;
    int unsigned w;
    int unsigned h;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 4))
        0: begin
          lo = $urandom_range(129, 255);
          hi = $urandom_range(0, 128);
        end
        1: begin
          lo = 0;
          hi = 255;
        end
        2: begin
          lo = $urandom_range(0, 255);
          hi = lo;
        end
        default: begin
          lo = $urandom_range(0, 200);
          hi = $urandom_range(lo, 255);
        end
      endcase
      write_reg(CFG_BAND_LOW, 21'(lo));
      write_reg(CFG_BAND_HIGH, 21'(hi));
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 19))
        0: begin
          w = 0;
          h = $urandom_range(1, 6);
        end
        1: begin
          w = $urandom_range(1025, 2047);
          h = 1;
        end
        2: begin
          w = $urandom_range(1, 6);
          h = 0;
        end
        3: begin
          w = 1;
          h = $urandom_range(1025, 2047);
        end
        4, 5: begin
          w = $urandom_range(9, 64);
          h = $urandom_range(1, 8);
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end
      endcase
      write_reg(CFG_WIDTH, 21'(w));
      write_reg(CFG_HEIGHT, 21'(h));
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_MIN_TOTAL, '0);
        1:       write_reg(CFG_MIN_TOTAL, 21'($urandom));
        2:       write_reg(CFG_MIN_TOTAL, 21'd1048576);
        default: write_reg(CFG_MIN_TOTAL, 21'($urandom_range(0, cur_w * cur_h / 2 + 2)));
      endcase
    end
  endtask

  initial begin
    int n;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // full band, pixel extremes, first row wins
    write_reg(CFG_BAND_LOW, '0);
    write_reg(CFG_BAND_HIGH, 21'd255);
    write_reg(CFG_MIN_TOTAL, '0);
    write_reg(CFG_WIDTH, 21'd4);
    write_reg(CFG_HEIGHT, 21'd2);
    send_pixel(8'd0);
    send_pixel(8'd255);
    repeat (6) send_pixel(8'($urandom_range(0, 255)));

    // inverted band counts nothing
    settle();
    write_reg(CFG_BAND_LOW, 21'd200);
    write_reg(CFG_BAND_HIGH, 21'd100);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd100);
    send_pixel(8'd200);
    repeat (4) send_pixel(8'd150);

    // single-value band, too few water pixels
    settle();
    write_reg(CFG_BAND_LOW, 21'd100);
    write_reg(CFG_BAND_HIGH, 21'd100);
    write_reg(CFG_MIN_TOTAL, 21'd5);
    send_pixel(8'd99);
    send_pixel(8'd100);
    send_pixel(8'd101);
    send_pixel(8'd100);
    send_pixel(8'd100);
    repeat (3) send_pixel(8'd0);

    // zero sizes act as one pixel frames; band edges
    settle();
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    write_reg(CFG_BAND_LOW, 21'd10);
    write_reg(CFG_BAND_HIGH, 21'd20);
    write_reg(CFG_MIN_TOTAL, '0);
    send_pixel(8'd9);
    send_pixel(8'd10);
    send_pixel(8'd20);
    send_pixel(8'd21);
    settle();
    write_reg(CFG_MIN_TOTAL, 21'd1);
    send_pixel(8'd9);
    send_pixel(8'd15);

    // oversized width clamps to the maximum
    settle();
    write_reg(CFG_WIDTH, 21'd2047);
    write_reg(CFG_HEIGHT, 21'd1);
    write_reg(CFG_BAND_LOW, '0);
    write_reg(CFG_BAND_HIGH, 21'd127);
    write_reg(CFG_MIN_TOTAL, 21'h1FFFFF);
    steady = 1'b1;
    repeat (1024) send_pixel(8'($urandom_range(0, 255)));
    settle();
    write_reg(CFG_MIN_TOTAL, '0);
    steady = 1'b0;

    // width shrinks part way along a row
    settle();
    write_reg(CFG_WIDTH, 21'd4);
    write_reg(CFG_HEIGHT, 21'd2);
    write_reg(CFG_BAND_HIGH, 21'd255);
    send_pixel(8'd1);
    send_pixel(8'd2);
    settle();
    write_reg(CFG_WIDTH, 21'd1);
    send_pixel(8'd3);
    send_pixel(8'd4);

    // remembered row left beyond a shrunk height
    settle();
    write_reg(CFG_BAND_LOW, 21'd100);
    write_reg(CFG_BAND_HIGH, 21'd100);
    write_reg(CFG_HEIGHT, 21'd8);
    repeat (5) send_pixel(8'd0);
    send_pixel(8'd100);
    settle();
    write_reg(CFG_HEIGHT, 21'd2);
    send_pixel(8'd0);

    // density above full scale after the height shrinks
    settle();
    write_reg(CFG_WIDTH, 21'd4);
    write_reg(CFG_HEIGHT, 21'd8);
    repeat (5) begin
      send_pixel(8'd100);
      repeat (3) send_pixel(8'd0);
    end
    settle();
    write_reg(CFG_HEIGHT, 21'd1);
    send_pixel(8'd100);
    repeat (3) send_pixel(8'd0);

    while (random_sent < 460) begin
      settle();
      reshape_config();
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 120);
      for (int i = 0; i < n; i++) begin
        if ((phase_no == 0 && i == n / 2) || $urandom_range(0, 399) == 0) settle();
        send_pixel(pick_pixel());
      end
      random_sent += n;
      phase_no++;
    end

    settle();
    if (failures == 0)
      $display("band_threshold_row_level_finder verification clean");
    else
      $display("band_threshold_row_level_finder verification failed");
    $finish;
  end

endmodule
